// File: design/plut_pkg.sv
// shared types, constants and color helpers for the palette lookup engine
`timescale 1ns / 1ps
package plut_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_IDX_W   = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int PAL_CNT_W   = PAL_IDX_W + 1;
    localparam int GAM_ENTRIES = 256;
    localparam int DIST_W      = 18;
    localparam int CQ_DEPTH    = 4;
    localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W    = CQ_PTR_W + 1;

    localparam logic RES_PIXEL   = 1'b0;
    localparam logic RES_NEAREST = 1'b1;

    typedef enum logic [1:0] {
        REQ_GAMMA   = 2'd0,
        REQ_PALETTE = 2'd1,
        REQ_PIXEL   = 2'd2,
        REQ_NEAREST = 2'd3
    } req_t;

    typedef struct packed {
        req_t       op;
        logic [7:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] gval;
        logic       in_range;
    } plut_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GAM_R,
        BK_GAM_G,
        BK_GAM_B,
        BK_PIX,
        BK_SEARCH
    } bk_state_t;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] x);
        return {x, x[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] x);
        return {x, x[5:4]};
    endfunction

    function automatic logic [15:0] sqdiff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {8'd0, d} * {8'd0, d};
    endfunction

endpackage

// File: design/plut_front.sv
// request intake: decodes the request and drops loads that have no effect
`timescale 1ns / 1ps
module plut_front (
    input  logic                [1:0] req_type,
    input  logic                [7:0] entry_index,
    input  logic                [7:0] red,
    input  logic                [7:0] green,
    input  logic                [7:0] blue,
    input  logic                [7:0] gamma_value,
    input  logic                      push,
    output logic                      full,
    input  logic                      cq_full,
    output logic                      cq_push,
    output plut_pkg::plut_cmd_t       cq_cmd
);
    import plut_pkg::*;

    logic accept;
    logic in_range;
    logic keep;
    req_t op;

    always_comb
    begin
        op = req_t'(req_type);
        in_range = ({1'b0, entry_index} < 9'(PAL_ENTRIES));
        // a palette load outside the palette is a no-op
        keep = !((op == REQ_PALETTE) && !in_range);
        accept = push && !cq_full;
        full = cq_full;
        cq_push = accept && keep;
        cq_cmd.op = op;
        cq_cmd.idx = entry_index;
        cq_cmd.red = red;
        cq_cmd.green = green;
        cq_cmd.blue = blue;
        cq_cmd.gval = gamma_value;
        cq_cmd.in_range = in_range;
    end

endmodule

// File: design/plut_cmd_queue.sv
// short command queue between intake and execution
`timescale 1ns / 1ps
module plut_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cq_push,
    input  plut_pkg::plut_cmd_t cq_cmd,
    output logic                cq_full,
    output logic                cq_valid,
    output plut_pkg::plut_cmd_t cq_head,
    input  logic                cq_pop
);
    import plut_pkg::*;

    plut_cmd_t            slot_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0]  wr_ptr_reg;
    logic [CQ_PTR_W-1:0]  wr_ptr_next;
    logic [CQ_PTR_W-1:0]  rd_ptr_reg;
    logic [CQ_PTR_W-1:0]  rd_ptr_next;
    logic [CQ_CNT_W-1:0]  count_reg;
    logic [CQ_CNT_W-1:0]  count_next;
    logic                 do_push;
    logic                 do_pop;

    always_comb
    begin
        cq_full = (count_reg == CQ_CNT_W'(CQ_DEPTH));
        cq_valid = (count_reg != '0);
        cq_head = slot_reg[rd_ptr_reg];
        do_push = cq_push && !cq_full;
        do_pop = cq_pop && cq_valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cq_cmd;
        end
    end

endmodule

// File: design/plut_back.sv
// execution side: gamma and palette memories, nearest search, result word register
`timescale 1ns / 1ps
module plut_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cq_valid,
    input  plut_pkg::plut_cmd_t cq_head,
    output logic                cq_pop,
    output logic                out_valid,
    input  logic                out_pop,
    output logic                out_kind,
    output logic [15:0]         out_color,
    output logic [7:0]          out_near
);
    import plut_pkg::*;

    logic [7:0]  gamma_mem   [GAM_ENTRIES];
    logic [15:0] palette_mem [PAL_ENTRIES];

    bk_state_t state_reg, state_next;
    plut_cmd_t cmd_reg, cmd_next;

    logic                 gam_we;
    logic [7:0]           gam_raddr;
    logic [7:0]           gam_rdata_reg;
    logic                 pal_we;
    logic [PAL_IDX_W-1:0] pal_waddr;
    logic [15:0]          pal_wdata;
    logic [PAL_IDX_W-1:0] pal_raddr;
    logic [15:0]          pal_rdata_reg;

    logic [7:0] gr_reg, gr_next;
    logic [7:0] gg_reg, gg_next;

    logic [PAL_CNT_W-1:0] issue_cnt_reg, issue_cnt_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [PAL_IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic                 sq_valid_reg, sq_valid_next;
    logic [PAL_IDX_W-1:0] sq_idx_reg, sq_idx_next;
    logic [15:0]          sq_r_reg, sq_r_next;
    logic [15:0]          sq_g_reg, sq_g_next;
    logic [15:0]          sq_b_reg, sq_b_next;
    logic [DIST_W-1:0]    best_d_reg, best_d_next;
    logic [PAL_IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]    dist_sum;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [15:0] out_color_reg, out_color_next;
    logic [7:0]  out_near_reg, out_near_next;
    logic        out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        cq_pop = 1'b0;
        gam_we = 1'b0;
        gam_raddr = cmd_reg.red;
        pal_we = 1'b0;
        pal_waddr = cmd_reg.idx[PAL_IDX_W-1:0];
        pal_wdata = pack565(gr_reg, gg_reg, gam_rdata_reg);
        pal_raddr = cmd_reg.idx[PAL_IDX_W-1:0];
        gr_next = gr_reg;
        gg_next = gg_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_valid_next = 1'b0;
        rd_idx_next = rd_idx_reg;
        sq_valid_next = 1'b0;
        sq_idx_next = sq_idx_reg;
        sq_r_next = sq_r_reg;
        sq_g_next = sq_g_reg;
        sq_b_next = sq_b_reg;
        best_d_next = best_d_reg;
        best_idx_next = best_idx_reg;
        dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
        out_free = !out_valid_reg || out_pop;
        out_valid_next = out_valid_reg && !out_pop;
        out_kind_next = out_kind_reg;
        out_color_next = out_color_reg;
        out_near_next = out_near_reg;

        case (state_reg)
            BK_IDLE:
            begin
                if (cq_valid)
                begin
                    case (cq_head.op)
                        REQ_GAMMA:
                        begin
                            cq_pop = 1'b1;
                            gam_we = 1'b1;
                        end
                        REQ_PALETTE:
                        begin
                            cq_pop = 1'b1;
                            cmd_next = cq_head;
                            gam_raddr = cq_head.red;
                            state_next = BK_GAM_R;
                        end
                        REQ_PIXEL:
                        begin
                            if (out_free)
                            begin
                                cq_pop = 1'b1;
                                cmd_next = cq_head;
                                pal_raddr = cq_head.idx[PAL_IDX_W-1:0];
                                state_next = BK_PIX;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cq_pop = 1'b1;
                                cmd_next = cq_head;
                                pal_raddr = '0;
                                rd_valid_next = 1'b1;
                                rd_idx_next = '0;
                                issue_cnt_next = PAL_CNT_W'(1);
                                best_d_next = '1;
                                best_idx_next = '0;
                                state_next = BK_SEARCH;
                            end
                        end
                    endcase
                end
            end
            BK_GAM_R:
            begin
                gr_next = gam_rdata_reg;
                gam_raddr = cmd_reg.green;
                state_next = BK_GAM_G;
            end
            BK_GAM_G:
            begin
                gg_next = gam_rdata_reg;
                gam_raddr = cmd_reg.blue;
                state_next = BK_GAM_B;
            end
            BK_GAM_B:
            begin
                pal_we = 1'b1;
                state_next = BK_IDLE;
            end
            BK_PIX:
            begin
                out_valid_next = 1'b1;
                out_kind_next = RES_PIXEL;
                out_color_next = cmd_reg.in_range ? pal_rdata_reg : 16'd0;
                out_near_next = 8'd0;
                state_next = BK_IDLE;
            end
            BK_SEARCH:
            begin
                // read, square and compare run as a three deep pipe
                if (issue_cnt_reg < PAL_CNT_W'(PAL_ENTRIES))
                begin
                    pal_raddr = issue_cnt_reg[PAL_IDX_W-1:0];
                    rd_valid_next = 1'b1;
                    rd_idx_next = issue_cnt_reg[PAL_IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    sq_valid_next = 1'b1;
                    sq_idx_next = rd_idx_reg;
                    sq_r_next = sqdiff(cmd_reg.red, expand5(pal_rdata_reg[15:11]));
                    sq_g_next = sqdiff(cmd_reg.green, expand6(pal_rdata_reg[10:5]));
                    sq_b_next = sqdiff(cmd_reg.blue, expand5(pal_rdata_reg[4:0]));
                end
                // strict compare keeps the lowest index on ties
                if (sq_valid_reg && (dist_sum < best_d_reg))
                begin
                    best_d_next = dist_sum;
                    best_idx_next = sq_idx_reg;
                end
                if ((issue_cnt_reg == PAL_CNT_W'(PAL_ENTRIES)) && !rd_valid_reg
                    && !sq_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next = RES_NEAREST;
                    out_color_next = 16'd0;
                    out_near_next = 8'(best_idx_reg);
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rd_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_valid_reg <= rd_valid_next;
            sq_valid_reg <= sq_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        gr_reg <= gr_next;
        gg_reg <= gg_next;
        issue_cnt_reg <= issue_cnt_next;
        rd_idx_reg <= rd_idx_next;
        sq_idx_reg <= sq_idx_next;
        sq_r_reg <= sq_r_next;
        sq_g_reg <= sq_g_next;
        sq_b_reg <= sq_b_next;
        best_d_reg <= best_d_next;
        best_idx_reg <= best_idx_next;
        out_kind_reg <= out_kind_next;
        out_color_reg <= out_color_next;
        out_near_reg <= out_near_next;
    end

    always_ff @(posedge clk)
    begin
        if (gam_we)
        begin
            gamma_mem[cq_head.idx] <= cq_head.gval;
        end
        gam_rdata_reg <= gamma_mem[gam_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            palette_mem[pal_waddr] <= pal_wdata;
        end
        pal_rdata_reg <= palette_mem[pal_raddr];
    end

    assign out_valid = out_valid_reg;
    assign out_kind = out_kind_reg;
    assign out_color = out_color_reg;
    assign out_near = out_near_reg;

endmodule

// File: design/palette_lut_rgb565_engine.sv
// palette lookup engine top level: intake, command queue and execution side
// a pushed word is registered in the queue before the execution side sees it; gamma
// load writes the gamma memory, palette load makes three gamma memory reads then a
// palette write, pixel convert reads one palette entry, nearest search reads all
// PAL_ENTRIES entries; each memory has a single read port; results wait in one register
// reset clears queue, state and result valid; memory contents hold nothing until loaded
`timescale 1ns / 1ps
module palette_lut_rgb565_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  req_type,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  gamma_value,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic        result_kind,
    output logic [15:0] pixel_color,
    output logic [7:0]  nearest_index
);
    import plut_pkg::*;

    logic      cq_full;
    logic      cq_push;
    logic      cq_valid;
    logic      cq_pop;
    plut_cmd_t cq_cmd;
    plut_cmd_t cq_head;
    logic      out_valid;

    plut_front u_front (
        .req_type    (req_type),
        .entry_index (entry_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .gamma_value (gamma_value),
        .push        (push),
        .full        (full),
        .cq_full     (cq_full),
        .cq_push     (cq_push),
        .cq_cmd      (cq_cmd)
    );

    plut_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cq_push  (cq_push),
        .cq_cmd   (cq_cmd),
        .cq_full  (cq_full),
        .cq_valid (cq_valid),
        .cq_head  (cq_head),
        .cq_pop   (cq_pop)
    );

    plut_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_valid  (cq_valid),
        .cq_head   (cq_head),
        .cq_pop    (cq_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_kind  (result_kind),
        .out_color (pixel_color),
        .out_near  (nearest_index)
    );

    assign empty = !out_valid;

`ifndef SYNTH
    a_queue_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        cq_full |-> cq_valid)
        else $error("command queue full without a head word");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(cq_push && cq_full))
        else $error("command pushed into a full queue");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        cq_pop |-> cq_valid)
        else $error("command popped from an empty queue");

    a_unused_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result_kind == RES_PIXEL && nearest_index == 8'd0)
                    || (result_kind == RES_NEAREST && pixel_color == 16'd0)))
        else $error("unused result field not zero");
`endif

endmodule
